// ----- hdl/ppf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ppf_pkg;

   localparam int unsigned NUM_PREFIXES_DEF   = 16;
   localparam int unsigned PREFIX_BYTES_DEF   = 64;
   localparam int unsigned MAX_PATH_BYTES_DEF = 255;

   localparam int unsigned EXCL_START_LIMIT = 200;
   localparam int unsigned EXCL_WORD_BYTES  = 5;
   localparam logic [8*EXCL_WORD_BYTES-1:0] EXCL_WORD = 40'h2F_68_64_61_73;
   localparam logic [7:0] SEP_CHAR = 8'h2F;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_PATH = 1'b1
   } func_type;

   typedef struct packed {
      func_type   func;
      logic [3:0] slot;
      logic [5:0] slot_pos;
      logic [7:0] byte_value;
      logic       last;
   } req_type;

   typedef struct packed {
      logic report;
      logic prefix_hit;
      logic excluded;
   } rsp_type;

   typedef struct packed {
      logic fire;
      logic take;
      logic last;
   } step_type;

endpackage

`default_nettype wire

// ----- hdl/path_prefix_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A final byte is registered with its table rows, then so is its verdict.
// Throughput: one beat per cycle, loads and path bytes alike, while no result
// is blocked; table rows for this and the next byte come from two read ports.
// Reset: synchronous; the prefix table reads as all zero at once through
// per-row valid bits, and all path state returns to its idle value.

module path_prefix_filter #(
   parameter int unsigned NUM_PREFIXES   = ppf_pkg::NUM_PREFIXES_DEF,
   parameter int unsigned PREFIX_BYTES   = ppf_pkg::PREFIX_BYTES_DEF,
   parameter int unsigned MAX_PATH_BYTES = ppf_pkg::MAX_PATH_BYTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ppf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ppf_pkg::rsp_type      rsp_data
);

   import ppf_pkg::*;

   localparam int unsigned AW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
   localparam int unsigned LW = (NUM_PREFIXES > 1) ? $clog2(NUM_PREFIXES) : 1;
   localparam int unsigned PW = $clog2(MAX_PATH_BYTES + 1);
   localparam int unsigned RW = 8 * NUM_PREFIXES;

   logic                    req_fire;
   logic                    is_path;
   logic                    load_ok;
   logic                    take;
   logic [PW-1:0]           npos;
   logic [PW-1:0]           f_pos_ff;
   logic                    f_ended_ff;
   logic [NUM_PREFIXES-1:0] used_ff;

   logic                    s1_valid_ff;
   logic                    s1_take_ff;
   logic                    s1_last_ff;
   logic [7:0]              s1_byte_ff;
   logic [PW-1:0]           s1_pos_ff;
   logic [PW-1:0]           s1_npos_ff;
   logic [NUM_PREFIXES-1:0] s1_used_ff;
   logic                    s1_advance;
   logic                    out_free;

   logic [RW-1:0]           row_a;
   logic [RW-1:0]           row_b;
   step_type                step;
   rsp_type                 match_rsp;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = !s1_valid_ff || !s1_last_ff || out_free;
   assign req_ready  = s1_advance;
   assign req_fire   = req_valid && req_ready;
   assign is_path    = req_data.func == FUNC_PATH;
   assign load_ok    = (32'(req_data.slot) < NUM_PREFIXES) &&
                       (32'(req_data.slot_pos) < PREFIX_BYTES);
   assign take       = !f_ended_ff && (32'(f_pos_ff) < MAX_PATH_BYTES);
   assign npos       = (take && req_data.byte_value != 8'h00) ? f_pos_ff + PW'(1) : f_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_pos_ff   <= '0;
         f_ended_ff <= 1'b0;
         used_ff    <= '0;
      end else if (req_fire) begin
         if (is_path) begin
            if (req_data.last) begin
               f_pos_ff   <= '0;
               f_ended_ff <= 1'b0;
            end else begin
               f_pos_ff   <= npos;
               f_ended_ff <= f_ended_ff | (take && req_data.byte_value == 8'h00);
            end
         end else if (load_ok && req_data.slot_pos == 6'd0) begin
            for (int i = 0; i < NUM_PREFIXES; i++) begin
               if (32'(req_data.slot) == i) begin
                  used_ff[i] <= req_data.byte_value != 8'h00;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_take_ff  <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else if (s1_advance) begin
         s1_valid_ff <= req_fire && is_path;
         s1_take_ff  <= take;
         s1_last_ff  <= req_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_data.byte_value;
         s1_pos_ff  <= f_pos_ff;
         s1_npos_ff <= npos;
         s1_used_ff <= used_ff;
      end
   end

   ppf_table #(
      .NUM_PREFIXES(NUM_PREFIXES),
      .PREFIX_BYTES(PREFIX_BYTES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_fire && !is_path && load_ok),
      .wr_addr  (AW'(req_data.slot_pos)),
      .wr_lane  (LW'(req_data.slot)),
      .wr_data  (req_data.byte_value),
      .rd_en    (req_fire && is_path),
      .rd_addr_a(AW'(f_pos_ff)),
      .rd_addr_b(AW'(npos)),
      .rd_row_a (row_a),
      .rd_row_b (row_b)
   );

   assign step.fire = s1_valid_ff && s1_advance;
   assign step.take = s1_valid_ff && s1_take_ff;
   assign step.last = s1_last_ff;

   ppf_match #(
      .NUM_PREFIXES  (NUM_PREFIXES),
      .PREFIX_BYTES  (PREFIX_BYTES),
      .MAX_PATH_BYTES(MAX_PATH_BYTES)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .byte_value(s1_byte_ff),
      .pos       (s1_pos_ff),
      .npos      (s1_npos_ff),
      .used      (s1_used_ff),
      .row_a     (row_a),
      .row_b     (row_b),
      .rsp       (match_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step.fire && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step.fire && s1_last_ff) begin
         rsp_data_ff <= match_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      32'(f_pos_ff) <= MAX_PATH_BYTES)
      else $error("path position beyond limit");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_path && req_data.last |=> f_pos_ff == '0 && !f_ended_ff)
      else $error("path state not cleared after final byte");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while result stage blocked");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      step.fire && s1_last_ff |=> rsp_valid_ff)
      else $error("final byte left no result beat");

endmodule

`default_nettype wire

// ----- hdl/ppf_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppf_table #(
   parameter int unsigned NUM_PREFIXES = ppf_pkg::NUM_PREFIXES_DEF,
   parameter int unsigned PREFIX_BYTES = ppf_pkg::PREFIX_BYTES_DEF,
   localparam int unsigned AW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1,
   localparam int unsigned LW = (NUM_PREFIXES > 1) ? $clog2(NUM_PREFIXES) : 1,
   localparam int unsigned RW = 8 * NUM_PREFIXES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [LW-1:0] wr_lane,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr_a,
   input  wire logic [AW-1:0] rd_addr_b,
   output logic      [RW-1:0] rd_row_a,
   output logic      [RW-1:0] rd_row_b
);

   logic [RW-1:0]           mem_ff [PREFIX_BYTES];
   logic [PREFIX_BYTES-1:0] row_vld_ff;
   logic [RW-1:0]           row_a_ff;
   logic [RW-1:0]           row_b_ff;
   logic                    vld_a_ff;
   logic                    vld_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (wr_en) begin
         row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // untouched row: zero the other lanes on first write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < NUM_PREFIXES; i++) begin
            if (wr_lane == LW'(i)) begin
               mem_ff[wr_addr][i*8 +: 8] <= wr_data;
            end else if (!row_vld_ff[wr_addr]) begin
               mem_ff[wr_addr][i*8 +: 8] <= 8'h00;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         row_a_ff <= mem_ff[rd_addr_a];
         row_b_ff <= mem_ff[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else if (rd_en) begin
         vld_a_ff <= row_vld_ff[rd_addr_a];
         vld_b_ff <= row_vld_ff[rd_addr_b];
      end
   end

   assign rd_row_a = vld_a_ff ? row_a_ff : '0;
   assign rd_row_b = vld_b_ff ? row_b_ff : '0;

endmodule

`default_nettype wire

// ----- hdl/ppf_match.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppf_match #(
   parameter int unsigned NUM_PREFIXES   = ppf_pkg::NUM_PREFIXES_DEF,
   parameter int unsigned PREFIX_BYTES   = ppf_pkg::PREFIX_BYTES_DEF,
   parameter int unsigned MAX_PATH_BYTES = ppf_pkg::MAX_PATH_BYTES_DEF,
   localparam int unsigned PW = $clog2(MAX_PATH_BYTES + 1),
   localparam int unsigned RW = 8 * NUM_PREFIXES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ppf_pkg::step_type step,
   input  wire logic [7:0]        byte_value,
   input  wire logic [PW-1:0]     pos,
   input  wire logic [PW-1:0]     npos,
   input  wire logic [NUM_PREFIXES-1:0] used,
   input  wire logic [RW-1:0]     row_a,
   input  wire logic [RW-1:0]     row_b,
   output ppf_pkg::rsp_type       rsp
);

   import ppf_pkg::*;

   localparam int unsigned WW = 8 * EXCL_WORD_BYTES;

   logic [NUM_PREFIXES-1:0] sm_ff, sm_in;
   logic [NUM_PREFIXES-1:0] pd_ff, pd_in;
   logic [WW-1:0]           rb_ff, rb_in;
   logic                    cp_ff, cp_in;
   logic                    ex_ff, ex_in;
   logic                    pos_in_tab;
   logic                    npos_in_tab;
   logic                    ex_fin;
   logic                    hit;

   assign pos_in_tab  = 32'(pos) < PREFIX_BYTES;
   assign npos_in_tab = 32'(npos) < PREFIX_BYTES;

   always_comb begin
      sm_in = sm_ff;
      pd_in = pd_ff;
      rb_in = rb_ff;
      cp_in = cp_ff;
      ex_in = ex_ff;
      if (step.take) begin
         if (byte_value == 8'h00) begin
            if (cp_ff) begin
               ex_in = 1'b1;
            end
         end else begin
            if (pos_in_tab) begin
               for (int i = 0; i < NUM_PREFIXES; i++) begin
                  if (sm_ff[i] && !pd_ff[i]) begin
                     if (row_a[i*8 +: 8] == 8'h00) begin
                        pd_in[i] = 1'b1;
                     end else if (row_a[i*8 +: 8] != byte_value) begin
                        sm_in[i] = 1'b0;
                     end
                  end
               end
            end
            if (cp_ff && byte_value == SEP_CHAR) begin
               ex_in = 1'b1;
            end
            rb_in = {rb_ff[WW-9:0], byte_value};
            cp_in = (rb_in == EXCL_WORD) && (32'(pos) >= EXCL_WORD_BYTES - 1) &&
                    (32'(pos) < EXCL_START_LIMIT + EXCL_WORD_BYTES - 1);
         end
      end
   end

   always_comb begin
      ex_fin = ex_in | cp_in;
      hit    = 1'b0;
      for (int i = 0; i < NUM_PREFIXES; i++) begin
         if (used[i] && sm_in[i] &&
             (pd_in[i] || !npos_in_tab || row_b[i*8 +: 8] == 8'h00)) begin
            hit = 1'b1;
         end
      end
      rsp.report     = hit & ~ex_fin;
      rsp.prefix_hit = hit;
      rsp.excluded   = ex_fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_ff <= '1;
         pd_ff <= '0;
         rb_ff <= '0;
         cp_ff <= 1'b0;
         ex_ff <= 1'b0;
      end else if (step.fire) begin
         if (step.last) begin
            sm_ff <= '1;
            pd_ff <= '0;
            rb_ff <= '0;
            cp_ff <= 1'b0;
            ex_ff <= 1'b0;
         end else begin
            sm_ff <= sm_in;
            pd_ff <= pd_in;
            rb_ff <= rb_in;
            cp_ff <= cp_in;
            ex_ff <= ex_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import ppf_pkg::*;

   localparam int unsigned N_DIRECTED  = 21;
   localparam int unsigned RANDOM_BEATS = 1000;
   localparam int unsigned MIN_VERDICTS = 60;
   localparam int unsigned CALM_AFTER  = 850;
   localparam int unsigned HOLD_AT     = 300;
   localparam int unsigned HOLD_CYCLES = 300;

   typedef struct packed {
      req_type beat;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   path_prefix_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   stim_row_type directed [N_DIRECTED] = '{
      '{'{FUNC_PATH, 4'd0,  6'd0,  "/",    1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  8'h00,  1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_LOAD, 4'd0,  6'd0,  "/",    1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_LOAD, 4'd0,  6'd1,  "a",    1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_LOAD, 4'd15, 6'd63, 8'hFF,  1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd15, 6'd63, "/",    1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  "a",    1'b1}, 1'b1, '{1'b1, 1'b1, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  "/",    1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  "/",    1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  "h",    1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  "d",    1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  "a",    1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  "s",    1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  "/",    1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  8'h00,  1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  "a",    1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  "/",    1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_LOAD, 4'd0,  6'd1,  "b",    1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd0,  6'd0,  "b",    1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_LOAD, 4'd15, 6'd0,  8'hFF,  1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{FUNC_PATH, 4'd9,  6'd42, 8'hFF,  1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}}
   };

   logic [7:0]                  prefix_copy [NUM_PREFIXES_DEF][PREFIX_BYTES_DEF];
   logic [NUM_PREFIXES_DEF-1:0] live_mask;
   logic [NUM_PREFIXES_DEF-1:0] done_mask;
   int unsigned                 path_len;
   bit                          path_closed;
   logic [39:0]                 window;
   bit                          tail_pending;
   bit                          tail_seen;

   rsp_type     verdict_q [$];
   int unsigned beats_counted;
   int unsigned table_writes;
   int unsigned verdicts_expected;
   int unsigned verdicts_seen;
   int unsigned hits_seen;
   int unsigned excl_seen;
   int unsigned errors;
   int unsigned long_paths;
   bit          calm;

   function automatic void clear_path_state();
      live_mask    = '1;
      done_mask    = '0;
      path_len     = 0;
      path_closed  = 1'b0;
      window       = '0;
      tail_pending = 1'b0;
      tail_seen    = 1'b0;
   endfunction

   function automatic void absorb_path_byte(logic [7:0] b);
      int unsigned i;
      int unsigned pos;
      pos = path_len;
      if (b == 8'h00) begin
         if (tail_pending)
            tail_seen = 1'b1;
         path_closed = 1'b1;
         return;
      end
      if (pos < PREFIX_BYTES_DEF) begin
         for (i = 0; i < NUM_PREFIXES_DEF; i++) begin
            if (live_mask[i] && !done_mask[i]) begin
               if (prefix_copy[i][pos] == 8'h00)
                  done_mask[i] = 1'b1;
               else if (prefix_copy[i][pos] != b)
                  live_mask[i] = 1'b0;
            end
         end
      end
      if (tail_pending && b == SEP_CHAR)
         tail_seen = 1'b1;
      window       = {window[31:0], b};
      tail_pending = (window == EXCL_WORD) && pos >= 4 && (pos - 4) < EXCL_START_LIMIT;
      path_len     = pos + 1;
   endfunction

   function automatic bit any_prefix_matched();
      int unsigned i;
      for (i = 0; i < NUM_PREFIXES_DEF; i++) begin
         if (prefix_copy[i][0] != 8'h00 && live_mask[i] &&
             (done_mask[i] || path_len >= PREFIX_BYTES_DEF ||
              prefix_copy[i][path_len] == 8'h00))
            return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit step_model(input req_type r, output rsp_type v);
      bit hit;
      v = '0;
      if (r.func == FUNC_LOAD) begin
         prefix_copy[r.slot][r.slot_pos] = r.byte_value;
         beats_counted++;
         table_writes++;
         return 1'b0;
      end
      if (!path_closed && path_len < MAX_PATH_BYTES_DEF) begin
         absorb_path_byte(r.byte_value);
         beats_counted++;
      end else if (r.last) begin
         beats_counted++;
      end
      if (!r.last)
         return 1'b0;
      if (tail_pending)
         tail_seen = 1'b1;
      hit          = any_prefix_matched();
      v.report     = hit && !tail_seen;
      v.prefix_hit = hit;
      v.excluded   = tail_seen;
      clear_path_state();
      verdicts_expected++;
      return 1'b1;
   endfunction

   task automatic flag_mismatch(string what);
      errors++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   task automatic idle_gap(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_beat(input req_type r, input bit typed = 1'b0,
                            input rsp_type want = '0);
      rsp_type v;
      if (!calm && $urandom_range(0, 9) == 0)
         idle_gap($urandom_range(1, 10));
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if (step_model(r, v))
         verdict_q.push_back(typed ? want : v);
   endtask

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 7))
         0, 1, 2: pick_char = EXCL_WORD[8 * $urandom_range(0, 4) +: 8];
         3:       pick_char = SEP_CHAR;
         4:       pick_char = "x";
         default: pick_char = 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic req_type noise_beat();
      req_type r;
      r.func       = func_type'($urandom_range(0, 1));
      r.slot       = 4'($urandom);
      r.slot_pos   = 6'($urandom);
      r.byte_value = 8'($urandom);
      r.last       = 1'($urandom);
      return r;
   endfunction

   task automatic write_prefix();
      req_type     r;
      int unsigned len;
      int unsigned j;
      r      = noise_beat();
      r.func = FUNC_LOAD;
      case ($urandom_range(0, 7))
         0:       len = 0;
         1:       len = PREFIX_BYTES_DEF;
         default: len = $urandom_range(1, 6);
      endcase
      for (j = 0; j < len; j++) begin
         r.slot_pos   = 6'(j);
         r.byte_value = pick_char();
         r.last       = 1'($urandom);
         send_beat(r);
      end
      if (len < PREFIX_BYTES_DEF) begin
         r.slot_pos   = 6'(len);
         r.byte_value = 8'h00;
         send_beat(r);
      end
   endtask

   task automatic send_path();
      logic [7:0]  p [$];
      req_type     r;
      int unsigned k;
      int unsigned j;
      int unsigned total;
      if ($urandom_range(0, 1)) begin
         k = $urandom_range(0, NUM_PREFIXES_DEF - 1);
         for (j = 0; j < PREFIX_BYTES_DEF && prefix_copy[k][j] != 8'h00; j++)
            p.push_back(prefix_copy[k][j]);
         if (p.size() > 0) begin
            case ($urandom_range(0, 3))
               0: void'(p.pop_back());
               1: p[$urandom_range(0, p.size() - 1)] = pick_char();
               default: ;
            endcase
         end
      end
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 2) == 0) begin
            for (j = 0; j < 5; j++)
               p.push_back(EXCL_WORD[8 * (4 - j) +: 8]);
            case ($urandom_range(0, 2))
               0:       p.push_back(SEP_CHAR);
               1:       ;
               default: p.push_back(pick_char());
            endcase
         end else begin
            p.push_back(SEP_CHAR);
            repeat ($urandom_range(1, 3))
               p.push_back(pick_char());
         end
      end
      if (long_paths < 2 && $urandom_range(0, 29) == 0) begin
         long_paths++;
         total = $urandom_range(192, 204);
         while (p.size() < total)
            p.push_back(pick_char());
         for (j = 0; j < 5; j++)
            p.push_back(EXCL_WORD[8 * (4 - j) +: 8]);
         p.push_back(SEP_CHAR);
         total = $urandom_range(230, 300);
         while (p.size() < total)
            p.push_back(pick_char());
      end
      if (p.size() > 1 && $urandom_range(0, 9) == 0)
         p[$urandom_range(0, p.size() - 1)] = 8'h00;
      if ($urandom_range(0, 29) == 0)
         p.delete();
      if (p.size() == 0)
         p.push_back(8'h00);
      for (j = 0; j < p.size(); j++) begin
         if ($urandom_range(0, 29) == 0) begin
            r      = noise_beat();
            r.func = FUNC_LOAD;
            send_beat(r);
         end
         r            = noise_beat();
         r.func       = FUNC_PATH;
         r.byte_value = p[j];
         r.last       = (j == p.size() - 1);
         send_beat(r);
      end
   endtask

   initial begin : receiver
      int unsigned n;
      bit          held;
      held      = 1'b0;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         // hold off long enough for the block to fill and stall its input
         if (!held && beats_counted >= HOLD_AT) begin
            held      = 1'b1;
            rsp_ready <= 1'b0;
            n         = HOLD_CYCLES;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n         = $urandom_range(1, 10);
         end else begin
            rsp_ready <= 1'b1;
            n         = $urandom_range(1, 20);
         end
         repeat (n - 1) @(negedge clock);
      end
   end

   always @(posedge clock) begin : check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            flag_mismatch($sformatf("result %b with none expected", rsp_data));
         end else begin
            want = verdict_q.pop_front();
            verdicts_seen++;
            if (want.prefix_hit)
               hits_seen++;
            if (want.excluded)
               excl_seen++;
            if (rsp_data.report !== want.report)
               flag_mismatch($sformatf("verdict %0d report %b, want %b",
                                       verdicts_seen, rsp_data.report, want.report));
            if (rsp_data.prefix_hit !== want.prefix_hit)
               flag_mismatch($sformatf("verdict %0d prefix_hit %b, want %b",
                                       verdicts_seen, rsp_data.prefix_hit, want.prefix_hit));
            if (rsp_data.excluded !== want.excluded)
               flag_mismatch($sformatf("verdict %0d excluded %b, want %b",
                                       verdicts_seen, rsp_data.excluded, want.excluded));
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int unsigned i;
      int unsigned j;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      calm      = 1'b0;
      for (i = 0; i < NUM_PREFIXES_DEF; i++)
         for (j = 0; j < PREFIX_BYTES_DEF; j++)
            prefix_copy[i][j] = 8'h00;
      clear_path_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++)
         send_beat(directed[i].beat, directed[i].typed, directed[i].want);

      while (beats_counted < RANDOM_BEATS || verdicts_expected < MIN_VERDICTS) begin
         calm = (beats_counted >= CALM_AFTER);
         case ($urandom_range(0, 9))
            0:       write_prefix();
            1:       repeat ($urandom_range(1, 4)) send_beat(noise_beat());
            default: send_path();
         endcase
      end
      calm = 1'b1;
      idle_gap(1);

      // drain, then allow for the registered result path
      while (verdict_q.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Ran %0d beats: %0d table writes, %0d path verdicts checked",
               beats_counted, table_writes, verdicts_seen);
      $display("Verdicts with a prefix hit: %0d, with the excluded component: %0d",
               hits_seen, excl_seen);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
